[hw/rtl/rrq_pkg.sv]
// Package for the round-robin request table: sizes, status codes and the
// command word passed from the classifier to the executing back end.
// No dependencies.
`default_nettype none
package rrq_pkg;

	// Number of peer servers; slots are numbered 1..SERVERS
	localparam int SERVERS = 16;
	localparam int IDX_W   = $clog2(SERVERS);
	localparam int SLOT_W  = $clog2(SERVERS + 1);

	// Fixed field widths
	localparam int SITE_W   = 8;
	localparam int SENDER_W = 8;
	localparam int SERVER_W = 5;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 3;
	localparam int OSLOT_W  = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 8;

	// Queue between front and back
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef enum logic [STATUS_W-1:0] {
		ST_ACCEPTED   = 3'd0,
		ST_WRONG_SITE = 3'd1,
		ST_FROM_SELF  = 3'd2,
		ST_STALE      = 3'd3,
		ST_BAD_SENDER = 3'd4,
		ST_SERVED     = 3'd5,
		ST_NONE       = 3'd6
	} status_t;

	typedef enum logic {
		OP_REQUEST = 1'b0,
		OP_TICK    = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OWN_SITE   = 2'd0,
		CFG_OWN_SERVER = 2'd1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CMD_REJECT = 2'd0,
		CMD_REQ    = 2'd1,
		CMD_TICK   = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		status_t           rej_status;
		logic [IDX_W-1:0]  idx;
		logic [WORD_W-1:0] stamp;
		logic [WORD_W-1:0] gseq;
		logic [WORD_W-1:0] lseq;
	} cmd_t;

	// Round-robin step over 1..SERVERS; zero or out of range wraps to 1
	function automatic logic [SLOT_W-1:0] next_pos(input logic [SLOT_W-1:0] p);
		logic [SLOT_W-1:0] r;
		if (p >= SLOT_W'(SERVERS))
			r = SLOT_W'(1);
		else
			r = p + SLOT_W'(1);
		return r;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/rrq_if.sv]
// Channel interfaces of the request table: item input, result output and
// configuration write. Depends on rrq_pkg.
`default_nettype none
interface rrq_in_if;
	import rrq_pkg::*;
	logic                valid;
	logic                ready;
	logic                operation;
	logic [SITE_W-1:0]   sender_site;
	logic [SENDER_W-1:0] sender_server;
	logic [WORD_W-1:0]   request_stamp;
	logic [WORD_W-1:0]   wanted_global_seq;
	logic [WORD_W-1:0]   wanted_local_seq;

	modport source (output valid, operation, sender_site, sender_server,
		request_stamp, wanted_global_seq, wanted_local_seq, input ready);
	modport sink (input valid, operation, sender_site, sender_server,
		request_stamp, wanted_global_seq, wanted_local_seq, output ready);
endinterface

interface rrq_out_if;
	import rrq_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [OSLOT_W-1:0]  served_slot;
	logic [WORD_W-1:0]   served_global_seq;
	logic [WORD_W-1:0]   served_local_seq;

	modport source (output valid, status, served_slot, served_global_seq,
		served_local_seq, input ready);
	modport sink (input valid, status, served_slot, served_global_seq,
		served_local_seq, output ready);
endinterface

interface rrq_cfg_if;
	import rrq_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/replay_checked_round_robin_requests_top.sv]
// Top level of the replay-checked round-robin request table: front end,
// command queue and back end. Depends on rrq_pkg, rrq_if, rrq_front,
// rrq_fifo, rrq_back.
//
//   channel   dir   carries
//   -------   ---   -------------------------------------------------------
//   items     in    operation, sender site/server, stamp, wanted seq numbers
//   results   out   status, served slot, served global/local seq numbers
//   cfg       in    register index and write data (own_site, own_server)
//
// A rejected request goes from the taken beat straight to the result stage;
// a checked request first does a registered stamp read, then the compare and write.
// A tick takes the beat, tests the pending flags one by one from the slot after
// the pointer, reads the served numbers and stages the result when a slot is
// served, or stages a no-pending result once every slot has been tested.
// Reset clears the pointer and all slot flags at once, and sets own_site to 0 and own_server to 1.
// A two-entry queue lets items be taken while the back end is busy or the
// result register is held by a stalled sink.
`default_nettype none
module replay_checked_round_robin_requests_top (
	input  wire logic clk,
	input  wire logic arst_n,
	rrq_in_if.sink    items,
	rrq_cfg_if.sink   cfg,
	rrq_out_if.source results
);
	import rrq_pkg::*;

	logic push_valid;
	logic push_ready;
	cmd_t push_data;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_data;

	rrq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	rrq_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	rrq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.results   (results)
	);

endmodule
`default_nettype wire

[hw/rtl/rrq_front.sv]
// Front end: holds the configuration registers, takes item beats and
// classifies them into commands for the queue. Depends on rrq_pkg, rrq_if.
`default_nettype none
module rrq_front (
	input  wire logic     clk,
	input  wire logic     arst_n,
	rrq_in_if.sink        items,
	rrq_cfg_if.sink       cfg,
	output logic          push_valid,
	input  wire logic     push_ready,
	output rrq_pkg::cmd_t push_data
);
	import rrq_pkg::*;

	logic [SITE_W-1:0]   own_site_q;
	logic [SERVER_W-1:0] own_server_q;
	logic [SENDER_W-1:0] sender_m1;

	// Configuration registers, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_site_q   <= '0;
			own_server_q <= SERVER_W'(1);
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_OWN_SITE:   own_site_q   <= cfg.data;
				CFG_OWN_SERVER: own_server_q <= cfg.data[SERVER_W-1:0];
				default: ;
			endcase
		end
	end

	// Beat goes straight into the queue when there is room
	assign items.ready = push_ready;
	assign push_valid  = items.valid;
	assign sender_m1   = items.sender_server - SENDER_W'(1);

	// Classification, checks in priority order
	always_comb begin
		push_data.kind       = CMD_REQ;
		push_data.rej_status = ST_ACCEPTED;
		push_data.idx        = sender_m1[IDX_W-1:0];
		push_data.stamp      = items.request_stamp;
		push_data.gseq       = items.wanted_global_seq;
		push_data.lseq       = items.wanted_local_seq;
		if (op_t'(items.operation) == OP_TICK) begin
			push_data.kind = CMD_TICK;
		end else if (items.sender_site != own_site_q) begin
			push_data.kind       = CMD_REJECT;
			push_data.rej_status = ST_WRONG_SITE;
		end else if (items.sender_server == SENDER_W'(own_server_q)) begin
			push_data.kind       = CMD_REJECT;
			push_data.rej_status = ST_FROM_SELF;
		end else if (items.sender_server == '0 ||
				items.sender_server > SENDER_W'(SERVERS)) begin
			push_data.kind       = CMD_REJECT;
			push_data.rej_status = ST_BAD_SENDER;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/rrq_fifo.sv]
// Short command queue between the front end and the back end.
// Depends on rrq_pkg.
`default_nettype none
module rrq_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire rrq_pkg::cmd_t push_data,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output rrq_pkg::cmd_t      pop_data
);
	import rrq_pkg::*;

	cmd_t              buf_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = buf_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push)
			buf_q[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

[hw/rtl/rrq_back.sv]
// Back end: slot memories, replay check, round-robin service scan and the
// result register. Depends on rrq_pkg, rrq_if.
`default_nettype none
module rrq_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          pop_valid,
	output logic               pop_ready,
	input  wire rrq_pkg::cmd_t pop_data,
	rrq_out_if.source          results
);
	import rrq_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_STAMP = 5'b00010,
		S_SCAN  = 5'b00100,
		S_FETCH = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	typedef struct packed {
		status_t            status;
		logic [OSLOT_W-1:0] slot;
		logic [WORD_W-1:0]  gseq;
		logic [WORD_W-1:0]  lseq;
	} res_t;

	state_t             state_q;
	cmd_t               cmd_q;
	logic [SLOT_W-1:0]  ptr_q;
	logic [SLOT_W-1:0]  scan_p_q;
	logic [SLOT_W-1:0]  first_q;
	logic [IDX_W-1:0]   cnt_q;
	logic [SERVERS-1:0] stamp_vld_q;
	logic [SERVERS-1:0] pend_q;
	res_t               stg_q;
	res_t               res_q;
	logic               res_valid_q;

	// Slot memories
	logic [WORD_W-1:0] stamp_mem [SERVERS];
	logic [WORD_W-1:0] gseq_mem  [SERVERS];
	logic [WORD_W-1:0] lseq_mem  [SERVERS];
	logic [WORD_W-1:0] stamp_rd_q;
	logic [WORD_W-1:0] gseq_rd_q;
	logic [WORD_W-1:0] lseq_rd_q;

	logic              take;
	logic              stamp_rd_en;
	logic [WORD_W-1:0] old_stamp;
	logic              fresh;
	logic              mem_we;
	logic [SLOT_W-1:0] scan_m1;
	logic [IDX_W-1:0]  scan_idx;
	logic              hit;
	logic              seq_rd_en;
	logic              scan_done;
	logic [SLOT_W-1:0] none_pos;
	logic              res_load;

	assign pop_ready   = (state_q == S_IDLE);
	assign take        = pop_valid && pop_ready;
	assign stamp_rd_en = take && (pop_data.kind == CMD_REQ);

	// Replay check against the stored stamp; unwritten slots read zero
	assign old_stamp = stamp_vld_q[cmd_q.idx] ? stamp_rd_q : '0;
	assign fresh     = cmd_q.stamp > old_stamp;
	assign mem_we    = (state_q == S_STAMP) && fresh;

	// Scan position and its pending flag
	assign scan_m1   = scan_p_q - SLOT_W'(1);
	assign scan_idx  = scan_m1[IDX_W-1:0];
	assign hit       = pend_q[scan_idx];
	assign seq_rd_en = (state_q == S_SCAN) && hit;
	assign scan_done = (cnt_q == IDX_W'(SERVERS - 1));
	assign none_pos  = next_pos(first_q);

	assign res_load  = (state_q == S_EMIT) && (!res_valid_q || results.ready);

	// Memory write and registered reads
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stamp_mem[cmd_q.idx] <= cmd_q.stamp;
			gseq_mem[cmd_q.idx]  <= cmd_q.gseq;
			lseq_mem[cmd_q.idx]  <= cmd_q.lseq;
		end
		if (stamp_rd_en)
			stamp_rd_q <= stamp_mem[pop_data.idx];
		if (seq_rd_en) begin
			gseq_rd_q <= gseq_mem[scan_idx];
			lseq_rd_q <= lseq_mem[scan_idx];
		end
	end

	// Control state: sequencer, pointer, slot flags, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ptr_q       <= '0;
			stamp_vld_q <= '0;
			pend_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load)
				res_valid_q <= 1'b1;
			else if (results.ready)
				res_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (take) begin
						case (pop_data.kind)
							CMD_REQ:  state_q <= S_STAMP;
							CMD_TICK: state_q <= S_SCAN;
							default:  state_q <= S_EMIT;
						endcase
					end
				end
				S_STAMP: begin
					if (fresh) begin
						stamp_vld_q[cmd_q.idx] <= 1'b1;
						pend_q[cmd_q.idx]      <= (cmd_q.gseq != '0) || (cmd_q.lseq != '0);
					end
					state_q <= S_EMIT;
				end
				S_SCAN: begin
					if (hit) begin
						ptr_q            <= scan_p_q;
						pend_q[scan_idx] <= 1'b0;
						state_q          <= S_FETCH;
					end else if (scan_done) begin
						ptr_q   <= none_pos;
						state_q <= S_EMIT;
					end
				end
				S_FETCH: state_q <= S_EMIT;
				S_EMIT: begin
					if (res_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command, scan registers and staged result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (take) begin
					cmd_q        <= pop_data;
					scan_p_q     <= next_pos(ptr_q);
					first_q      <= next_pos(ptr_q);
					cnt_q        <= '0;
					stg_q.status <= pop_data.rej_status;
					stg_q.slot   <= OSLOT_W'(ptr_q);
					stg_q.gseq   <= '0;
					stg_q.lseq   <= '0;
				end
			end
			S_STAMP: begin
				stg_q.status <= fresh ? ST_ACCEPTED : ST_STALE;
			end
			S_SCAN: begin
				if (!hit && scan_done) begin
					stg_q.status <= ST_NONE;
					stg_q.slot   <= OSLOT_W'(none_pos);
				end else if (!hit) begin
					scan_p_q <= next_pos(scan_p_q);
					cnt_q    <= cnt_q + IDX_W'(1);
				end
			end
			S_FETCH: begin
				stg_q.status <= ST_SERVED;
				stg_q.slot   <= OSLOT_W'(ptr_q);
				stg_q.gseq   <= gseq_rd_q;
				stg_q.lseq   <= lseq_rd_q;
			end
			default: ;
		endcase
		if (res_load)
			res_q <= stg_q;
	end

	// Result channel
	assign results.valid             = res_valid_q;
	assign results.status            = res_q.status;
	assign results.served_slot       = res_q.slot;
	assign results.served_global_seq = res_q.gseq;
	assign results.served_local_seq  = res_q.lseq;

endmodule
`default_nettype wire

[tb/replay_checked_round_robin_requests_top_test.sv]
// Self-checking testbench for the replay-checked round-robin request table.
// Depends on rrq_pkg, rrq_if and replay_checked_round_robin_requests_top; a
// small scoreboard class predicts every result and checks it in order.
`timescale 1ns / 100ps

module replay_checked_round_robin_requests_top_test;
	import rrq_pkg::*;

	localparam int RANDOM_PER_PHASE = 235;
	localparam int PHASES           = 8;
	localparam int QUIET_LIMIT      = 4000;
	localparam int MAX_REPORTS      = 30;

	typedef struct packed {
		op_t                 op;
		logic [SITE_W-1:0]   site;
		logic [SENDER_W-1:0] sender;
		logic [WORD_W-1:0]   stamp;
		logic [WORD_W-1:0]   gseq;
		logic [WORD_W-1:0]   lseq;
	} table_item_t;

	typedef struct packed {
		status_t            status;
		logic [OSLOT_W-1:0] slot;
		logic [WORD_W-1:0]  gseq;
		logic [WORD_W-1:0]  lseq;
	} table_result_t;

	// Scoreboard: own copy of the slot table, pointer and registers
	class request_table_tracker;
		logic [WORD_W-1:0]   last_stamp  [1:SERVERS];
		logic [WORD_W-1:0]   want_global [1:SERVERS];
		logic [WORD_W-1:0]   want_local  [1:SERVERS];
		logic [OSLOT_W-1:0]  pointer;
		logic [SITE_W-1:0]   site_reg;
		logic [SERVER_W-1:0] server_reg;
		table_result_t       due_results [$];
		int                  mismatches;
		int                  results_seen;
		int                  status_count [7];

		function new();
			for (int i = 1; i <= SERVERS; i++) begin
				last_stamp[i]  = '0;
				want_global[i] = '0;
				want_local[i]  = '0;
			end
			for (int i = 0; i < 7; i++)
				status_count[i] = 0;
			pointer      = '0;
			site_reg     = '0;
			server_reg   = SERVER_W'(1);
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function void set_register(cfg_idx_t idx, logic [CFG_DAT_W-1:0] value);
			case (idx)
				CFG_OWN_SITE:   site_reg = value;
				CFG_OWN_SERVER: server_reg = value[SERVER_W-1:0];
				default: ;
			endcase
		endfunction

		// Round-robin step over 1..SERVERS, zero and overflow go to 1
		function logic [OSLOT_W-1:0] advance(logic [OSLOT_W-1:0] p);
			if (p == '0 || p >= OSLOT_W'(SERVERS))
				return OSLOT_W'(1);
			return p + OSLOT_W'(1);
		endfunction

		// Work out the result of one accepted beat and queue it
		function void note_item(table_item_t it);
			table_result_t r;
			logic [OSLOT_W-1:0] p;
			int steps;
			r.status = ST_ACCEPTED;
			r.slot   = pointer;
			r.gseq   = '0;
			r.lseq   = '0;
			if (it.op == OP_REQUEST) begin
				if (it.site != site_reg)
					r.status = ST_WRONG_SITE;
				else if (it.sender == SENDER_W'(server_reg))
					r.status = ST_FROM_SELF;
				else if (it.sender == '0 || it.sender > SENDER_W'(SERVERS))
					r.status = ST_BAD_SENDER;
				else if (it.stamp <= last_stamp[it.sender])
					r.status = ST_STALE;
				else begin
					last_stamp[it.sender]  = it.stamp;
					want_global[it.sender] = it.gseq;
					want_local[it.sender]  = it.lseq;
				end
			end else begin
				// scan; an empty table costs SERVERS+1 extra steps
				p = advance(pointer);
				steps = 0;
				while (want_global[p] == '0 && want_local[p] == '0 && steps <= SERVERS) begin
					p = advance(p);
					steps++;
				end
				pointer = p;
				r.slot  = p;
				if (want_global[p] == '0 && want_local[p] == '0)
					r.status = ST_NONE;
				else begin
					r.status       = ST_SERVED;
					r.gseq         = want_global[p];
					r.lseq         = want_local[p];
					want_global[p] = '0;
					want_local[p]  = '0;
				end
			end
			status_count[r.status]++;
			due_results.push_back(r);
		endfunction

		task report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
			if (mismatches < MAX_REPORTS)
				$display("result %0d: %s got %0h, expected %0h", results_seen, what, got,
					want);
			mismatches++;
		endtask

		task check_result(logic [STATUS_W-1:0] st, logic [OSLOT_W-1:0] slot,
				logic [WORD_W-1:0] g, logic [WORD_W-1:0] l);
			table_result_t w;
			results_seen++;
			if (due_results.size() == 0) begin
				report_mismatch("result with nothing outstanding, status", WORD_W'(st), '0);
				return;
			end
			w = due_results.pop_front();
			if (st !== w.status)
				report_mismatch("status", WORD_W'(st), WORD_W'(w.status));
			if (slot !== w.slot)
				report_mismatch("served_slot", WORD_W'(slot), WORD_W'(w.slot));
			if (g !== w.gseq)
				report_mismatch("served_global_seq", g, w.gseq);
			if (l !== w.lseq)
				report_mismatch("served_local_seq", l, w.lseq);
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   sender_idle_pct;
	int   receiver_stall_pct;
	int   items_sent;
	int   quiet_cycles;

	request_table_tracker tracker = new();

	rrq_in_if  item_bus ();
	rrq_out_if result_bus ();
	rrq_cfg_if cfg_bus ();

	replay_checked_round_robin_requests_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (item_bus),
		.cfg     (cfg_bus),
		.results (result_bus)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Result sink with random back-pressure
	always @(posedge clk) begin
		result_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	// Check every result beat
	always @(posedge clk) begin
		if (arst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
			tracker.check_result(result_bus.status, result_bus.served_slot,
				result_bus.served_global_seq, result_bus.served_local_seq);
	end

	// Watchdog: too long without any beat on any channel
	always @(posedge clk) begin
		if (!arst_n || (item_bus.valid && item_bus.ready) ||
				(result_bus.valid && result_bus.ready) || (cfg_bus.valid && cfg_bus.ready))
			quiet_cycles = 0;
		else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout after %0d quiet cycles", quiet_cycles);
				$display("replay_checked_round_robin_requests_top: mismatch");
				$finish;
			end
		end
	end

	task automatic write_register(cfg_idx_t idx, logic [CFG_DAT_W-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		cfg_bus.valid <= 1'b0;
		tracker.set_register(idx, value);
	endtask

	task automatic send_item(table_item_t it);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		item_bus.valid             <= 1'b1;
		item_bus.operation         <= it.op;
		item_bus.sender_site       <= it.site;
		item_bus.sender_server     <= it.sender;
		item_bus.request_stamp     <= it.stamp;
		item_bus.wanted_global_seq <= it.gseq;
		item_bus.wanted_local_seq  <= it.lseq;
		do @(posedge clk); while (item_bus.ready !== 1'b1);
		tracker.note_item(it);
		items_sent++;
	endtask

	// Stop sending, wait for all results, then let the back end settle
	task automatic drain();
		item_bus.valid <= 1'b0;
		while (tracker.due_results.size() != 0)
			@(posedge clk);
		repeat (SERVERS + 6) @(posedge clk);
	endtask

	function automatic table_item_t request(logic [SITE_W-1:0] site,
			logic [SENDER_W-1:0] sender, logic [WORD_W-1:0] stamp,
			logic [WORD_W-1:0] g, logic [WORD_W-1:0] l);
		table_item_t it;
		it.op     = OP_REQUEST;
		it.site   = site;
		it.sender = sender;
		it.stamp  = stamp;
		it.gseq   = g;
		it.lseq   = l;
		return it;
	endfunction

	function automatic table_item_t tick();
		table_item_t it;
		it        = request(SITE_W'($urandom), SENDER_W'($urandom), $urandom, $urandom,
			$urandom);
		it.op     = OP_TICK;
		return it;
	endfunction

	function automatic logic [WORD_W-1:0] random_seq();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return '0;
		if (r < 4)
			return $urandom_range(1, 255);
		return $urandom;
	endfunction

	// Mostly well-formed requests and ticks, with some noise of each reject kind
	function automatic table_item_t random_item();
		table_item_t it;
		int roll;
		int w;
		logic [SENDER_W-1:0] s;
		logic [63:0] room;
		logic [63:0] hop;
		s = SENDER_W'($urandom_range(1, SERVERS));
		if (s == SENDER_W'(tracker.server_reg))
			s = SENDER_W'((s % SERVERS) + 1);
		it = request(tracker.site_reg, s, '0, random_seq(), random_seq());
		roll = $urandom_range(0, 99);
		if (roll < 35)
			it = tick();
		else if (roll < 85) begin
			room = 64'hFFFF_FFFF - 64'(tracker.last_stamp[s]);
			if (room == 0)
				it.stamp = '1;
			else begin
				w   = $urandom_range(0, 26);
				hop = 64'd1 + (64'($urandom) & ((64'd1 << w) - 64'd1));
				if (hop > room)
					hop = room;
				it.stamp = WORD_W'(64'(tracker.last_stamp[s]) + hop);
			end
		end else if (roll < 89)
			it.stamp = $urandom_range(0, tracker.last_stamp[s]);
		else if (roll < 93) begin
			it      = request(SITE_W'($urandom), SENDER_W'($urandom), $urandom, $urandom,
				$urandom);
			it.site = tracker.site_reg ^ SITE_W'($urandom_range(1, 255));
		end else if (roll < 96) begin
			it.sender = SENDER_W'(tracker.server_reg);
			it.stamp  = $urandom;
		end else begin
			it.sender = ($urandom_range(0, 3) == 0) ? '0 :
				SENDER_W'($urandom_range(SERVERS + 1, 255));
			it.stamp  = $urandom;
		end
		return it;
	endfunction

	// Reject order, stamp edges, overwrite and a full service round
	task automatic directed_items();
		send_item(tick());
		send_item(request(8'hC3, 8'd5, 32'd1, 32'd1, 32'd1));
		send_item(request(8'hC3, 8'd0, 32'd0, 32'd0, 32'd0));
		send_item(request(8'h3C, 8'd16, 32'd5, 32'd5, 32'd5));
		send_item(request(8'h3C, 8'd0, 32'd5, 32'd5, 32'd5));
		send_item(request(8'h3C, 8'd17, 32'd5, 32'd5, 32'd5));
		send_item(request(8'h3C, 8'd255, 32'd5, 32'd5, 32'd5));
		send_item(request(8'h3C, 8'd1, 32'd0, 32'd9, 32'd9));
		send_item(request(8'h3C, 8'd1, 32'd1, '1, '1));
		send_item(request(8'h3C, 8'd1, 32'd1, 32'd2, 32'd2));
		send_item(request(8'h3C, 8'd15, '1, 32'd0, 32'd5));
		send_item(request(8'h3C, 8'd15, '1, 32'd3, 32'd3));
		send_item(request(8'h3C, 8'd2, 32'd10, 32'd7, 32'd0));
		send_item(request(8'h3C, 8'd3, 32'd10, 32'd0, 32'd0));
		send_item(request(8'h3C, 8'd1, 32'd2, 32'h11, 32'h22));
		repeat (5) send_item(tick());
	endtask

	initial begin
		logic [SITE_W-1:0]   site;
		logic [SERVER_W-1:0] server;
		arst_n                     <= 1'b0;
		item_bus.valid             <= 1'b0;
		item_bus.operation         <= OP_REQUEST;
		item_bus.sender_site       <= '0;
		item_bus.sender_server     <= '0;
		item_bus.request_stamp     <= '0;
		item_bus.wanted_global_seq <= '0;
		item_bus.wanted_local_seq  <= '0;
		cfg_bus.valid              <= 1'b0;
		cfg_bus.index              <= CFG_OWN_SITE;
		cfg_bus.data               <= '0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		items_sent         = 0;
		quiet_cycles       = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_register(CFG_OWN_SITE, 8'h3C);
		write_register(CFG_OWN_SERVER, 8'd16);
		directed_items();

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				0: begin site = 8'h00; server = 5'd1;  end
				1: begin site = 8'hFF; server = 5'd16; end
				2: begin site = 8'h5A; server = 5'd9;  end
				3: begin site = 8'hA5; server = 5'd2;  end
				default: begin
					site   = SITE_W'($urandom);
					server = SERVER_W'($urandom_range(1, SERVERS));
				end
			endcase
			write_register(CFG_OWN_SITE, site);
			write_register(CFG_OWN_SERVER, CFG_DAT_W'(server));
			case (ph % 4)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 60; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 60; end
				default: begin sender_idle_pct = 9; receiver_stall_pct = 9; end
			endcase
			repeat (RANDOM_PER_PHASE) send_item(random_item());
		end
		drain();

		if (tracker.due_results.size() != 0)
			tracker.report_mismatch("results never delivered, count",
				tracker.due_results.size(), '0);
		$display("%0d items checked over %0d register settings and four idling patterns",
			items_sent, PHASES + 1);
		$display("%0d accepted, %0d rejected, %0d served, %0d ticks with nothing pending",
			tracker.status_count[ST_ACCEPTED],
			tracker.status_count[ST_WRONG_SITE] + tracker.status_count[ST_FROM_SELF] +
			tracker.status_count[ST_STALE] + tracker.status_count[ST_BAD_SENDER],
			tracker.status_count[ST_SERVED], tracker.status_count[ST_NONE]);
		if (tracker.mismatches == 0)
			$display("replay_checked_round_robin_requests_top: match");
		else
			$display("replay_checked_round_robin_requests_top: mismatch");
		$finish;
	end

endmodule
